@@ design/afg_pkg.sv @@
// shared types, constants and helpers for the audio fade gain ramp
// no dependencies; imported by every module of the block
package afg_pkg;

   localparam int LEVEL_FRAC_BITS = 15;
   localparam int LEVEL_W         = 16;
   localparam int CFG_W           = 18;
   localparam int CMD_W           = 3;
   localparam int FADE_W          = 2;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [LEVEL_W-1:0] ONE_LEVEL = LEVEL_W'(1) << LEVEL_FRAC_BITS;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK        = 3'd0,
      CMD_FADE_IN     = 3'd1,
      CMD_FADE_OUT    = 3'd2,
      CMD_CANCEL      = 3'd3,
      CMD_ARM_PAUSE   = 3'd4,
      CMD_LOAD_MASTER = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      OP_TICK,
      OP_FADE_IN,
      OP_FADE_OUT,
      OP_CANCEL,
      OP_ARM_PAUSE,
      OP_LOAD,
      OP_NOP
   } op_type;

   localparam logic [FADE_W-1:0] FADE_NONE = 2'd0;
   localparam logic [FADE_W-1:0] FADE_IN   = 2'd1;
   localparam logic [FADE_W-1:0] FADE_OUT  = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [LEVEL_W-1:0] parent_level;
      logic [LEVEL_W-1:0] fade_step;
      logic [LEVEL_W-1:0] fade_target;
      logic               stop_at_end;
      logic [LEVEL_W-1:0] new_master_level;
   } req_word_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] gain;
      logic [LEVEL_W-1:0] master_out;
      logic [FADE_W-1:0]  fade_state;
      logic               stop_event;
      logic               pause_event;
   } rsp_word_type;

   // decoded word held between front and back, levels already saturated
   typedef struct packed {
      op_type             op;
      logic [LEVEL_W-1:0] parent;
      logic [LEVEL_W-1:0] step;
      logic [LEVEL_W-1:0] target;
      logic               stop;
      logic [LEVEL_W-1:0] level;
   } op_word_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   function automatic logic [LEVEL_W-1:0] sat_level(input logic [LEVEL_W-1:0] v);
      logic [LEVEL_W-1:0] r;
      r = (v > ONE_LEVEL) ? ONE_LEVEL : v;
      return r;
   endfunction

endpackage

@@ design/afg_queue.sv @@
// small word queue between the decode front and the execute back
// depends on afg_pkg for the decoded word type
module afg_queue #(
   parameter int DEPTH = afg_pkg::QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  afg_pkg::op_word_type          wdata,
   input  logic                          pop,
   output afg_pkg::op_word_type          rdata,
   output afg_pkg::queue_status_type     status
);
   import afg_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   op_word_type        mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign rdata        = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

@@ design/afg_front.sv @@
// decode front: classifies the request word and saturates its levels
// depends on afg_pkg for word types and the level helper
module afg_front (
   input  afg_pkg::req_word_type req_word,
   output afg_pkg::op_word_type  op_word
);
   import afg_pkg::*;

   op_type op;

   always_comb begin
      case (req_word.command)
         CMD_TICK:        op = OP_TICK;
         CMD_FADE_IN:     op = OP_FADE_IN;
         CMD_FADE_OUT:    op = OP_FADE_OUT;
         CMD_CANCEL:      op = OP_CANCEL;
         CMD_ARM_PAUSE:   op = OP_ARM_PAUSE;
         CMD_LOAD_MASTER: op = OP_LOAD;
         default:         op = OP_NOP;
      endcase
   end

   assign op_word.op     = op;
   assign op_word.parent = sat_level(req_word.parent_level);
   assign op_word.step   = req_word.fade_step;
   assign op_word.target = sat_level(req_word.fade_target);
   assign op_word.stop   = req_word.stop_at_end;
   assign op_word.level  = sat_level(req_word.new_master_level);

endmodule

@@ design/afg_back.sv @@
// execute back: ramp state, two-step gain multiply and the result register
// depends on afg_pkg for word types, codes and level constants
module afg_back (
   input  logic                          clock,
   input  logic                          reset,
   input  afg_pkg::op_word_type          op_word,
   input  afg_pkg::queue_status_type     q_status,
   output logic                          q_pop,
   input  logic [afg_pkg::CFG_W-1:0]     chan_volume,
   input  logic                          rsp_pop,
   output logic                          rsp_empty,
   output afg_pkg::rsp_word_type         rsp_word
);
   import afg_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_MULT
   } state_type;

   state_type          state_ff, state_in;
   logic [LEVEL_W-1:0] master_ff, master_in;
   logic [FADE_W-1:0]  mode_ff, mode_in;
   logic [LEVEL_W-1:0] step_ff, step_in;
   logic [LEVEL_W-1:0] end_ff, end_in;
   logic               stop_flag_ff, stop_flag_in;
   logic               pause_flag_ff, pause_flag_in;
   logic               stop_ev_ff, stop_ev_in;
   logic               pause_ev_ff, pause_ev_in;
   logic [LEVEL_W:0]   prod_ff, prod_in;
   logic [LEVEL_W-1:0] parent_ff, parent_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_ff, rsp_in;

   logic [LEVEL_W-1:0]   chvol;
   logic                 slot_free;
   logic [LEVEL_W:0]     ramp_up;
   logic                 ended;
   logic [2*LEVEL_W-1:0] mul1;
   logic [2*LEVEL_W:0]   mul2;

   always_comb begin
      if (chan_volume[CFG_W-1]) begin
         chvol = '0;
      end else if (chan_volume[CFG_W-2:0] > (CFG_W-1)'(ONE_LEVEL)) begin
         chvol = ONE_LEVEL;
      end else begin
         chvol = chan_volume[LEVEL_W-1:0];
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_pop;
   assign ramp_up   = {1'b0, master_ff} + {1'b0, step_ff};
   assign mul1      = chvol * master_in;
   assign mul2      = prod_ff * parent_ff;

   always_comb begin
      state_in      = state_ff;
      master_in     = master_ff;
      mode_in       = mode_ff;
      step_in       = step_ff;
      end_in        = end_ff;
      stop_flag_in  = stop_flag_ff;
      pause_flag_in = pause_flag_ff;
      stop_ev_in    = stop_ev_ff;
      pause_ev_in   = pause_ev_ff;
      prod_in       = prod_ff;
      parent_in     = parent_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_pop;
      rsp_in        = rsp_ff;
      q_pop         = 1'b0;
      ended         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty && (slot_free || op_word.op == OP_TICK)) begin
               q_pop       = 1'b1;
               stop_ev_in  = 1'b0;
               pause_ev_in = 1'b0;
               case (op_word.op)
                  OP_TICK: begin
                     if (mode_ff == FADE_IN) begin
                        if (ramp_up >= {1'b0, end_ff}) begin
                           master_in = end_ff;
                           ended     = 1'b1;
                        end else begin
                           master_in = ramp_up[LEVEL_W-1:0];
                        end
                     end else if (mode_ff == FADE_OUT) begin
                        if (step_ff >= master_ff || master_ff - step_ff <= end_ff) begin
                           master_in = end_ff;
                           ended     = 1'b1;
                        end else begin
                           master_in = master_ff - step_ff;
                        end
                     end
                     if (ended) begin
                        mode_in = FADE_NONE;
                        if (stop_flag_ff) begin
                           stop_flag_in = 1'b0;
                           master_in    = ONE_LEVEL;
                           stop_ev_in   = 1'b1;
                        end else if (mode_ff == FADE_OUT && pause_flag_ff) begin
                           pause_flag_in = 1'b0;
                           master_in     = ONE_LEVEL;
                           pause_ev_in   = 1'b1;
                        end
                     end
                     prod_in   = mul1[2*LEVEL_W-1:LEVEL_FRAC_BITS];
                     parent_in = op_word.parent;
                     state_in  = ST_MULT;
                  end
                  OP_FADE_IN, OP_FADE_OUT: begin
                     mode_in      = (op_word.op == OP_FADE_IN) ? FADE_IN : FADE_OUT;
                     step_in      = op_word.step;
                     end_in       = op_word.target;
                     stop_flag_in = op_word.stop;
                  end
                  OP_CANCEL: begin
                     mode_in      = FADE_NONE;
                     stop_flag_in = 1'b0;
                  end
                  OP_ARM_PAUSE: begin
                     stop_flag_in  = 1'b0;
                     pause_flag_in = 1'b1;
                  end
                  OP_LOAD: begin
                     master_in = op_word.level;
                  end
                  default: begin
                  end
               endcase
               if (op_word.op != OP_TICK) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.gain        = '0;
                  rsp_in.master_out  = master_in;
                  rsp_in.fade_state  = mode_in;
                  rsp_in.stop_event  = 1'b0;
                  rsp_in.pause_event = 1'b0;
               end
            end
         end
         ST_MULT: begin
            if (slot_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.gain        = mul2[LEVEL_FRAC_BITS+LEVEL_W-1:LEVEL_FRAC_BITS];
               rsp_in.master_out  = master_ff;
               rsp_in.fade_state  = mode_ff;
               rsp_in.stop_event  = stop_ev_ff;
               rsp_in.pause_event = pause_ev_ff;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         master_ff     <= ONE_LEVEL;
         mode_ff       <= FADE_NONE;
         step_ff       <= '0;
         end_ff        <= '0;
         stop_flag_ff  <= 1'b0;
         pause_flag_ff <= 1'b0;
         stop_ev_ff    <= 1'b0;
         pause_ev_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         master_ff     <= master_in;
         mode_ff       <= mode_in;
         step_ff       <= step_in;
         end_ff        <= end_in;
         stop_flag_ff  <= stop_flag_in;
         pause_flag_ff <= pause_flag_in;
         stop_ev_ff    <= stop_ev_in;
         pause_ev_ff   <= pause_ev_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      prod_ff   <= prod_in;
      parent_ff <= parent_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

@@ design/audio_fade_gain_ramp.sv @@
// top level of the audio fade gain ramp: decode front, word queue, execute back
// depends on afg_pkg, afg_front, afg_queue and afg_back
// a tick passes the product register, then the result register; other words only the latter
// throughput: other words one per cycle while the result slot is free; a tick word holds
// the back in ST_MULT until its result is registered; queue holds QUEUE_DEPTH words between
// reset: synchronous; master level 1.0, no fade, flags clear, channel volume 1.0
module audio_fade_gain_ramp #(
   parameter int QUEUE_DEPTH = afg_pkg::QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  afg_pkg::req_word_type         req_word,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output afg_pkg::rsp_word_type         rsp_word,
   input  logic                          csr_we,
   input  logic [afg_pkg::CFG_W-1:0]     csr_wdata
);
   import afg_pkg::*;

   logic [CFG_W-1:0]  chan_volume_ff;
   op_word_type       front_word;
   op_word_type       queue_word;
   queue_status_type  q_status;
   logic              q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_volume_ff <= CFG_W'(ONE_LEVEL);
      end else if (csr_we) begin
         chan_volume_ff <= csr_wdata;
      end
   end

   afg_front u_front (
      .req_word (req_word),
      .op_word  (front_word)
   );

   afg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (req_push),
      .wdata  (front_word),
      .pop    (q_pop),
      .rdata  (queue_word),
      .status (q_status)
   );

   assign req_full = q_status.full;

   afg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .op_word     (queue_word),
      .q_status    (q_status),
      .q_pop       (q_pop),
      .chan_volume (chan_volume_ff),
      .rsp_pop     (rsp_pop),
      .rsp_empty   (rsp_empty),
      .rsp_word    (rsp_word)
   );

   a_one_event: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> !(rsp_word.stop_event && rsp_word.pause_event))
      else $error("stop and pause event in one word");

   a_event_restores: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_word.stop_event || rsp_word.pause_event)) |->
      (rsp_word.master_out == ONE_LEVEL && rsp_word.fade_state == FADE_NONE))
      else $error("event without master reset and fade end");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_word.master_out <= ONE_LEVEL && rsp_word.gain <= ONE_LEVEL))
      else $error("level above unity");

   a_pop_needs_word: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("back popped an empty queue");

endmodule
